FILE: rtl/core/bgj_pkg.sv
// Package for the block generation journal: field types, codes and constants.
// Used by the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package bgj_pkg;

  localparam int NumBlocks = 1048576;
  localparam int MaxBlocksPerIo = 16;
  localparam int AddrW = 20;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam int GenW = 2;

  typedef enum logic [1:0] {
    REQ_WRITE      = 2'd0,
    REQ_READ_SKIP  = 2'd1,
    REQ_READ_INIT  = 2'd2,
    REQ_COMMIT     = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_SKIP      = 3'd1,
    ACT_WRITE     = 3'd2,
    ACT_COMMITTED = 3'd3,
    ACT_ERROR     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_READ,
    ST_WRITE,
    ST_COMMIT
  } bgj_state_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [AddrW-1:0]  first_block;
    logic [CntW-1:0]   num_blocks;
  } req_t;

  typedef struct packed {
    action_e           action;
    logic [GenW-1:0]   generation;
    logic [IdxW-1:0]   block_offset;
    logic              last;
  } rsp_t;

  // Generation sequence 0->1->2->3->1; zero is never reached again.
  function automatic logic [GenW-1:0] next_gen(input logic [GenW-1:0] g);
    logic [GenW-1:0] r;
    r = (g == 2'd3) ? 2'd1 : g + 2'd1;
    return r;
  endfunction

endpackage

FILE: rtl/core/block_generation_journal_top.sv
// Top level of the block generation journal: request sequencer around the cell RAM.
// Depends on bgj_pkg and bgj_ram.
`timescale 1ns / 1ps

// Usage:
// A request is presented on req_i with start; it is taken at a clock edge where start is
// high and busy is low. Results appear on rsp_o for one cycle each, marked by rsp_valid_o;
// the receiver cannot stall, so every strobed cycle is one delivered transaction.
// A request over n blocks first reads its n cells from the generation RAM, one per cycle,
// and then waits for the last read to return. Reads then emit n results; a write
// claim emits n results while clearing the cells; a skip emits one result. A commit
// writes the pending generations back, one per cycle, and emits one result on the last.
// A bad range or a commit with nothing pending gives one error result the cycle after
// acceptance and leaves busy low. The time a request occupies is set by the single read
// and single write port of the cell RAM.
// After reset the block clears all 1,048,576 entries of the cell RAM, one entry per cycle;
// busy stays high during that pass. Results are registered and appear in the cycle after
// the cycle that forms them, and busy is low while the last result is on the ports.

module block_generation_journal_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bgj_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output bgj_pkg::rsp_t rsp_o
);

  import bgj_pkg::*;

  bgj_state_e state_q, state_d;

  logic [AddrW-1:0] clr_q;
  logic [IdxW-1:0]  cnt_q;
  logic             rd_pend_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic             any_zero_q, all_zero_q;
  logic             pend_valid_q;
  logic [AddrW-1:0] pfirst_q;
  logic [CntW-1:0]  pcount_q;

  req_type_e        type_q;
  logic [AddrW-1:0] first_q;
  logic [CntW-1:0]  n_q;
  logic [GenW-1:0]  gens_q [MaxBlocksPerIo];
  logic [GenW-1:0]  pend_gen_q [MaxBlocksPerIo];

  logic             rsp_valid_d, rsp_valid_q;
  rsp_t             rsp_d, rsp_q;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [GenW-1:0]  ram_wdata, ram_rdata;

  logic             accept;
  logic             range_bad, commit_bad;
  logic             any_zero_c, all_zero_c;
  logic             cnt_last;
  logic [CntW-1:0]  cnt_limit;
  logic             go_write, go_skip;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  assign range_bad = (req_i.num_blocks == '0) ||
                     (req_i.num_blocks > CntW'(MaxBlocksPerIo)) ||
                     (({1'b0, req_i.first_block} + (AddrW+1)'(req_i.num_blocks)) >
                      (AddrW+1)'(NumBlocks));
  assign commit_bad = !pend_valid_q;

  // The last read of a scan returns in the decide cycle, so fold it in here.
  assign any_zero_c = any_zero_q || (rd_pend_q && (ram_rdata == '0));
  assign all_zero_c = all_zero_q && !(rd_pend_q && (ram_rdata != '0));

  assign cnt_limit = (state_q == ST_COMMIT) ? pcount_q : n_q;
  assign cnt_last  = ({1'b0, cnt_q} == (cnt_limit - CntW'(1)));

  assign go_write = (type_q == REQ_WRITE) || ((type_q == REQ_READ_INIT) && any_zero_c);
  assign go_skip  = (type_q == REQ_READ_SKIP) && all_zero_c;

  bgj_ram #(
    .Width (GenW),
    .Depth (NumBlocks)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_COMMIT) begin
            if (!commit_bad) state_d = ST_COMMIT;
          end else if (!range_bad) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (go_write) state_d = ST_WRITE;
        else if (go_skip)      state_d = ST_IDLE;
        else                   state_d = ST_READ;
      end
      ST_READ, ST_WRITE, ST_COMMIT: begin
        if (cnt_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: RAM controls and the next result.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = first_q + AddrW'(cnt_q);
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = first_q + AddrW'(cnt_q);
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ST_IDLE: begin
        if (accept && ((req_i.req_type == REQ_COMMIT) ? commit_bad : range_bad)) begin
          rsp_valid_d  = 1'b1;
          rsp_d.action = ACT_ERROR;
          rsp_d.last   = 1'b1;
        end
      end
      ST_SCAN: begin
        ram_re = 1'b1;
      end
      ST_DECIDE: begin
        if (!go_write && go_skip) begin
          rsp_valid_d  = 1'b1;
          rsp_d.action = ACT_SKIP;
          rsp_d.last   = 1'b1;
        end
      end
      ST_READ: begin
        rsp_valid_d        = 1'b1;
        rsp_d.action       = ACT_READ;
        rsp_d.generation   = gens_q[cnt_q];
        rsp_d.block_offset = cnt_q;
        rsp_d.last         = cnt_last;
      end
      ST_WRITE: begin
        ram_we             = 1'b1;
        rsp_valid_d        = 1'b1;
        rsp_d.action       = ACT_WRITE;
        rsp_d.generation   = next_gen(gens_q[cnt_q]);
        rsp_d.block_offset = cnt_q;
        rsp_d.last         = cnt_last;
      end
      ST_COMMIT: begin
        ram_we    = 1'b1;
        ram_waddr = pfirst_q + AddrW'(cnt_q);
        ram_wdata = pend_gen_q[cnt_q];
        if (cnt_last) begin
          rsp_valid_d  = 1'b1;
          rsp_d.action = ACT_COMMITTED;
          rsp_d.last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      cnt_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_idx_q     <= '0;
      any_zero_q   <= 1'b0;
      all_zero_q   <= 1'b1;
      pend_valid_q <= 1'b0;
      pfirst_q     <= '0;
      pcount_q     <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      rd_pend_q   <= ram_re;
      rd_idx_q    <= cnt_q;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else if (state_q != ST_IDLE && state_q != ST_CLEAR) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      if (state_q == ST_IDLE && accept) begin
        any_zero_q <= 1'b0;
        all_zero_q <= 1'b1;
      end else if (rd_pend_q) begin
        any_zero_q <= any_zero_c;
        all_zero_q <= all_zero_c;
      end
      if (state_q == ST_WRITE && cnt_last) begin
        pend_valid_q <= 1'b1;
        pfirst_q     <= first_q;
        pcount_q     <= n_q;
      end else if (state_q == ST_COMMIT && cnt_last) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Request fields, scan buffer, pending generations and the result register.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == ST_IDLE && accept) begin
      type_q  <= req_i.req_type;
      first_q <= req_i.first_block;
      n_q     <= req_i.num_blocks;
    end
    if (rd_pend_q) begin
      gens_q[rd_idx_q] <= ram_rdata;
    end
    if (state_q == ST_WRITE) begin
      pend_gen_q[cnt_q] <= next_gen(gens_q[cnt_q]);
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: rtl/core/bgj_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; depends on nothing.
`timescale 1ns / 1ps

module bgj_ram #(
  parameter int Width = 2,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
